[hdl/trlp_pkg.sv]
`default_nettype none

package trlp_pkg;

  // Input kinds carried on s_tuser
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Column numbers
  localparam logic [2:0] COL_YEAR   = 3'd0;
  localparam logic [2:0] COL_MONTH  = 3'd1;
  localparam logic [2:0] COL_DAY    = 3'd2;
  localparam logic [2:0] COL_HOUR   = 3'd3;
  localparam logic [2:0] COL_MINUTE = 3'd4;
  localparam logic [2:0] COL_LAST   = 3'd5;
  localparam logic [2:0] COL_MAX    = 3'd7;

  localparam int unsigned DATA_W = 56;

  typedef struct packed {
    logic [2:0]  column;
    logic [15:0] acc;
    logic        neg;
    logic        skip;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
  } line_state_t;

  typedef struct packed {
    logic        from_stream_end;
    logic signed [7:0] temp_value;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [15:0] year;
  } record_t;

endpackage

`default_nettype wire

[hdl/trlp_step.sv]
`default_nettype none

// Next line state and record for one byte or end-of-input request.
module trlp_step (
  input  wire logic                  cmd,
  input  wire logic [7:0]            char_byte,
  input  wire trlp_pkg::line_state_t state,
  output trlp_pkg::line_state_t      state_next,
  output logic                       rec_valid,
  output trlp_pkg::record_t          rec
);

  logic [7:0]  acc_low;
  logic [15:0] acc_digit;

  assign acc_low   = state.acc[7:0];
  // acc * 10 + digit, modulo 2^16
  assign acc_digit = {state.acc[12:0], 3'b000} + {state.acc[14:0], 1'b0}
                   + {8'd0, char_byte - trlp_pkg::CH_ZERO};

  always_comb begin
    rec.year       = state.year;
    rec.month      = state.month;
    rec.day        = state.day;
    rec.hour       = state.hour;
    rec.minute     = state.minute;
    rec.temp_value = state.neg ? 8'(8'd0 - acc_low) : acc_low;
    rec.from_stream_end = (cmd == trlp_pkg::CMD_END);
  end

  always_comb begin
    state_next = state;
    rec_valid  = 1'b0;
    priority if (cmd == trlp_pkg::CMD_END) begin
      rec_valid  = !state.skip && (state.column == trlp_pkg::COL_LAST);
      state_next = '0;
    end else if (state.skip) begin
      if (char_byte == trlp_pkg::CH_NEWLINE) begin
        state_next = '0;
      end
    end else if (char_byte == trlp_pkg::CH_MINUS) begin
      state_next.neg = 1'b1;
    end else if (char_byte == trlp_pkg::CH_SEMI) begin
      unique case (state.column)
        trlp_pkg::COL_YEAR:   state_next.year   = state.acc;
        trlp_pkg::COL_MONTH:  state_next.month  = acc_low;
        trlp_pkg::COL_DAY:    state_next.day    = acc_low;
        trlp_pkg::COL_HOUR:   state_next.hour   = acc_low;
        trlp_pkg::COL_MINUTE: state_next.minute = acc_low;
        default: ;
      endcase
      if (state.column != trlp_pkg::COL_MAX) begin
        state_next.column = state.column + 3'd1;
      end
      state_next.acc = '0;
      state_next.neg = 1'b0;
    end else if (char_byte == trlp_pkg::CH_NEWLINE) begin
      rec_valid  = 1'b1;
      state_next = '0;
    end else if (char_byte >= trlp_pkg::CH_ZERO && char_byte <= trlp_pkg::CH_NINE) begin
      state_next.acc = acc_digit;
    end else if (char_byte == trlp_pkg::CH_SPACE) begin
      state_next = state;
    end else begin
      state_next.skip = 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/temperature_record_line_parser_core.sv]
// Temperature record line parser.
// Input channel (s_*): one request per text byte. s_tdata carries the byte,
// s_tuser says whether it is a character (0) or the end of the input (1).
// Lines look like year;month;day;hour;minute;temperature and end in newline.
// Output channel (m_*): one record per newline, and one at end of input when
// exactly five semicolons were seen on the unfinished line; m_tuser marks the
// records completed by end of input. A line with any unexpected byte is
// dropped up to and including its newline.
// Throughput: one request per cycle while s_tready is high. The line
// state updates in the same cycle the byte is accepted (a compare and a
// multiply by ten). A record is registered in the output register or skid entry.
// Stall: the output register plus one skid entry hold records while m_tready
// is low; bytes that make no record keep flowing, and s_tready drops only
// once both entries are full.
// Reset (rst, synchronous): clears the line state and empties the output.
`default_nettype none

module temperature_record_line_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
  input  wire logic        s_tuser,   // [0] cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // temp_value, minute, hour, day, month, year (MSB to LSB)
  output logic             m_tuser    // [0] from_stream_end
);

  trlp_pkg::line_state_t state;
  trlp_pkg::line_state_t state_next;
  trlp_pkg::record_t     rec;
  logic                  rec_valid;

  logic [55:0] skid_data;
  logic        skid_user;
  logic        skid_valid;

  logic s_accept;
  logic push;
  logic out_free;

  trlp_step u_step (
    .cmd        (s_tuser),
    .char_byte  (s_tdata),
    .state      (state),
    .state_next (state_next),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  assign s_tready = !skid_valid;
  assign s_accept = s_tvalid && s_tready;
  assign push     = s_accept && rec_valid;
  // Output register can take a new record this cycle
  assign out_free = !m_tvalid || (m_tready && !skid_valid);

  // Line state: advance on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s_accept) begin
      state <= state_next;
    end
  end

  // Output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && m_tready && skid_valid) begin
      // drain skid into the output; input is held off so push is low here
      m_tvalid   <= 1'b1;
      skid_valid <= push;
    end else if (out_free) begin
      m_tvalid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready && skid_valid) begin
      m_tdata <= skid_data;
      m_tuser <= skid_user;
    end else if (out_free) begin
      if (push) begin
        m_tdata <= rec[trlp_pkg::DATA_W-1:0];
        m_tuser <= rec.from_stream_end;
      end
    end else if (push) begin
      skid_data <= rec[trlp_pkg::DATA_W-1:0];
      skid_user <= rec.from_stream_end;
    end
  end

endmodule

`default_nettype wire

[hdl/trlp_checker.sv]
`default_nettype none

module trlp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic        m_tuser
);

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled record changed");

  // A digit never makes a record
  a_digit_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == trlp_pkg::CMD_CHAR &&
    s_tdata >= trlp_pkg::CH_ZERO && s_tdata <= trlp_pkg::CH_NINE && !m_tvalid
    |=> !m_tvalid)
    else $error("record from a digit");

  // End of input gives either nothing or a record marked as such
  a_end_marked: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == trlp_pkg::CMD_END && !m_tvalid
    |=> !m_tvalid || m_tuser)
    else $error("end-of-input record not marked");

endmodule

bind temperature_record_line_parser_core trlp_checker u_trlp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/sv/temperature_record_line_parser_core_test.sv]
`timescale 1ns / 1ps

module temperature_record_line_parser_core_test;

  localparam int unsigned DIGIT_BASE   = 10;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned QUIET_TAIL   = 200;
  localparam int unsigned LONG_HOLD    = 64;

  // Tracks the line state of the parser and holds the records it must emit.
  class record_checker;
    logic [2:0]  column;
    logic [15:0] acc;
    logic        neg;
    logic        skip;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    trlp_pkg::record_t expected_records[$];
    int unsigned seen_requests;
    int unsigned mismatches;

    function new();
      seen_requests = 0;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      column = trlp_pkg::COL_YEAR;
      acc = '0;
      neg = 1'b0;
      skip = 1'b0;
      year = '0;
      month = '0;
      day = '0;
      hour = '0;
      minute = '0;
    endfunction

    function void push_record(logic at_end);
      trlp_pkg::record_t rec;
      logic [7:0] low;
      low = acc[7:0];
      rec.year = year;
      rec.month = month;
      rec.day = day;
      rec.hour = hour;
      rec.minute = minute;
      rec.temp_value = neg ? 8'(8'd0 - low) : low;
      rec.from_stream_end = at_end;
      expected_records.push_back(rec);
    endfunction

    function int unsigned pending();
      return expected_records.size();
    endfunction

    // Advance the line state by one accepted request.
    function void note_request(logic cmd, logic [7:0] ch);
      seen_requests++;
      if (cmd == trlp_pkg::CMD_END) begin
        if (!skip && column == trlp_pkg::COL_LAST) push_record(1'b1);
        clear_line();
        return;
      end
      if (skip) begin
        if (ch == trlp_pkg::CH_NEWLINE) clear_line();
        return;
      end
      if (ch == trlp_pkg::CH_MINUS) begin
        neg = 1'b1;
      end else if (ch == trlp_pkg::CH_SEMI) begin
        case (column)
          trlp_pkg::COL_YEAR:   year = acc;
          trlp_pkg::COL_MONTH:  month = acc[7:0];
          trlp_pkg::COL_DAY:    day = acc[7:0];
          trlp_pkg::COL_HOUR:   hour = acc[7:0];
          trlp_pkg::COL_MINUTE: minute = acc[7:0];
          default: ;
        endcase
        if (column != trlp_pkg::COL_MAX) column = column + 3'd1;
        acc = '0;
        neg = 1'b0;
      end else if (ch == trlp_pkg::CH_NEWLINE) begin
        push_record(1'b0);
        clear_line();
      end else if (ch >= trlp_pkg::CH_ZERO && ch <= trlp_pkg::CH_NINE) begin
        acc = 16'(acc * DIGIT_BASE + (ch - trlp_pkg::CH_ZERO));
      end else if (ch != trlp_pkg::CH_SPACE) begin
        skip = 1'b1;
      end
    endfunction

    function void compare_field(string fname, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %h, got %h", $time, fname, want, got);
      end
    endfunction

    function void check_record(trlp_pkg::record_t got);
      trlp_pkg::record_t want;
      if (expected_records.size() == 0) begin
        mismatches++;
        $display("%0t: record with none expected: expected nothing, got %h", $time, got);
        return;
      end
      want = expected_records.pop_front();
      compare_field("year", want.year, got.year);
      compare_field("month", {8'h00, want.month}, {8'h00, got.month});
      compare_field("day", {8'h00, want.day}, {8'h00, got.day});
      compare_field("hour", {8'h00, want.hour}, {8'h00, got.hour});
      compare_field("minute", {8'h00, want.minute}, {8'h00, got.minute});
      compare_field("temp_value", {8'h00, want.temp_value}, {8'h00, got.temp_value});
      compare_field("from_stream_end", {15'd0, want.from_stream_end},
                    {15'd0, got.from_stream_end});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tuser;

  record_checker sb = new();
  bit bursts_on = 1'b1;
  bit hold_request = 1'b0;
  int unsigned random_goal;

  temperature_record_line_parser_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Observe both channels at the clock edge; requests before records.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_record({m_tuser, m_tdata});
    end
  end

  // Receiver: random short stalls, plus one long hold when asked.
  initial begin
    int unsigned stall;
    logic ready;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        stall--;
        ready = 1'b0;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 2);
        ready = 1'b0;
      end else begin
        ready = 1'b1;
      end
      m_tready <= ready;
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_item(logic cmd, logic [7:0] ch);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(string txt);
    for (int i = 0; i < txt.len(); i++) send_item(trlp_pkg::CMD_CHAR, txt[i]);
  endtask

  task automatic drain_records();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Byte that drops the line: high half, letters and nearby signs, or control codes.
  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(128, 255));
      1: return 8'($urandom_range(8'h41, 8'h7A));
      default: return 8'($urandom_range(8'h00, 8'h09));
    endcase
  endfunction

  // One number with occasional sign, spaces and overflowing length.
  task automatic send_field();
    int unsigned nd;
    nd = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
    if ($urandom_range(0, 5) == 0) send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_MINUS);
    for (int i = 0; i < nd; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_SPACE);
      send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 15) == 0) send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_MINUS);
  endtask

  // Close a line by newline, or now and then by end of input.
  task automatic end_line();
    if ($urandom_range(0, 9) == 0) send_item(trlp_pkg::CMD_END, 8'($urandom_range(0, 255)));
    else send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_NEWLINE);
  endtask

  task automatic send_random_line();
    int unsigned kind;
    int unsigned bad_at;
    int unsigned cols;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      // well-formed record, random content
      for (int c = 0; c <= trlp_pkg::COL_LAST; c++) begin
        send_field();
        if (c < trlp_pkg::COL_LAST) send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_SEMI);
      end
      end_line();
    end else if (kind < 75) begin
      // record broken by a stray byte in one column
      bad_at = $urandom_range(0, trlp_pkg::COL_LAST);
      for (int c = 0; c <= trlp_pkg::COL_LAST; c++) begin
        if (c == bad_at) send_item(trlp_pkg::CMD_CHAR, odd_byte());
        send_field();
        if (c < trlp_pkg::COL_LAST) send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_SEMI);
      end
      end_line();
    end else if (kind < 85) begin
      // random column count, often too few or too many
      cols = $urandom_range(0, 9);
      for (int c = 0; c < cols; c++) begin
        send_field();
        send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_SEMI);
      end
      send_field();
      end_line();
    end else if (kind < 93) begin
      repeat ($urandom_range(0, 3)) send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_SPACE);
      end_line();
    end else begin
      repeat ($urandom_range(1, 6)) send_item(trlp_pkg::CMD_CHAR, 8'($urandom_range(0, 255)));
      end_line();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = trlp_pkg::CMD_CHAR;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty line, year overflow with sign in month and end of
    // input after five separators, a dropped line closed by end of input,
    // and a column index run up to saturation with a negative extreme.
    send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_NEWLINE);
    send_text("99999;-1;;;;");
    send_item(trlp_pkg::CMD_END, 8'hFF);
    send_item(trlp_pkg::CMD_CHAR, 8'hFF);
    send_item(trlp_pkg::CMD_END, 8'h00);
    send_text(";;;;;;;-128\n");

    // Pause until everything is out, then fill the output while it stalls.
    drain_records();
    random_goal = sb.seen_requests + RANDOM_ITEMS;
    hold_request = 1'b1;
    repeat (16) send_item(trlp_pkg::CMD_CHAR, trlp_pkg::CH_NEWLINE);

    while (sb.seen_requests < random_goal) begin
      if (sb.seen_requests + QUIET_TAIL >= random_goal) bursts_on = 1'b0;
      send_random_line();
    end

    drain_records();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
hdl/trlp_pkg.sv
hdl/trlp_step.sv
hdl/temperature_record_line_parser_core.sv
hdl/trlp_checker.sv
tb/sv/temperature_record_line_parser_core_test.sv
